FILE: src/nested_run_time_accounting_stack_unit_defines.svh
// Assertion macros shared by the run-time accounting stack files.
`ifndef NESTED_RUN_TIME_ACCOUNTING_STACK_UNIT_DEFINES_SVH
`define NESTED_RUN_TIME_ACCOUNTING_STACK_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define NRTAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define NRTAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/nrtas_pkg.sv
// Shared constants and types of the run-time accounting stack.
package nrtas_pkg;

	// Default deepest tracked nesting level.
	localparam int MAX_LEVEL_DEF = 8;

	// Event modes.
	localparam logic [2:0] MODE_TASK_RESTART = 3'd0;
	localparam logic [2:0] MODE_TASK_READ    = 3'd1;
	localparam logic [2:0] MODE_ENTER        = 3'd2;
	localparam logic [2:0] MODE_LEAVE        = 3'd3;
	localparam logic [2:0] MODE_SCHED_START  = 3'd4;
	localparam logic [2:0] MODE_SCHED_END    = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;	// capture the incoming word
		logic read;	// read the stack entry of the current level
		logic exec;	// update state and load the result registers
	} ctl_cmd_t;

endpackage

FILE: src/nrtas_ctrl.sv
// Controller state machine and output handshake of the run-time accounting stack.
module nrtas_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output nrtas_pkg::ctl_cmd_t cmd
);
	import nrtas_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_EXEC = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// The result register can take a new word once the old one is gone or leaving.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.read = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/nrtas_dpath.sv
// Datapath of the run-time accounting stack: level stack, counters and result registers.
module nrtas_dpath #(
	parameter int MAX_LEVEL = nrtas_pkg::MAX_LEVEL_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nrtas_pkg::ctl_cmd_t cmd,
	input  logic [2:0]          mode,
	input  logic [31:0]         time_now,
	output logic [31:0]         popped_time,
	output logic [31:0]         task_time,
	output logic [31:0]         task_time_add,
	output logic [31:0]         sched_time_add,
	output logic [31:0]         overflow_events,
	output logic [31:0]         underflow_events,
	output logic [31:0]         misuse_events,
	output logic [63:0]         overflow_level_time,
	output logic [31:0]         overflow_level_runs,
	output logic [31:0]         nesting_level,
	output logic                fatal
);
	import nrtas_pkg::*;

	localparam int          DEPTH = MAX_LEVEL + 1;
	localparam int          LVL_W = $clog2(DEPTH);
	localparam logic [31:0] MAX_N = 32'(MAX_LEVEL);
	localparam logic [LVL_W-1:0] LVL_ZERO = '0;
	localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);

	// Level stack.
	logic [31:0] stamp_q [DEPTH];
	logic [31:0] accum_q [DEPTH];

	// Scalar state.
	logic [31:0] nest_q;
	logic [31:0] ovf_q;
	logic [31:0] unf_q;
	logic [31:0] mis_q;
	logic [63:0] deep_q;
	logic [31:0] runs_q;
	logic        halted_q;

	// Captured word and values read from the stack.
	logic [2:0]  mode_s1;
	logic [31:0] time_s1;
	logic [31:0] elapsed_s2;
	logic [31:0] accum_s2;
	logic [31:0] accum0_s2;

	// Result time registers.
	logic [31:0] popped_q;
	logic [31:0] task_q;
	logic [31:0] tadd_q;
	logic [31:0] sadd_q;

	logic [LVL_W-1:0] idx;
	logic [31:0]      level_sum;

	// Next-state values and stack write controls.
	logic [31:0]      nest_d;
	logic [31:0]      ovf_d;
	logic [31:0]      unf_d;
	logic [31:0]      mis_d;
	logic [63:0]      deep_d;
	logic [31:0]      runs_d;
	logic             halt_d;
	logic             st_we;
	logic [LVL_W-1:0] st_wa;
	logic             acc_we;
	logic [LVL_W-1:0] acc_wa;
	logic [31:0]      acc_wd;
	logic             clr_we;
	logic [LVL_W-1:0] clr_wa;
	logic [31:0]      popped_d;
	logic [31:0]      task_d;
	logic [31:0]      tadd_d;
	logic [31:0]      sadd_d;

	// Stack index of the current level; levels beyond the stack never use it.
	assign idx       = (nest_q <= MAX_N) ? nest_q[LVL_W-1:0] : LVL_ZERO;
	assign level_sum = accum_s2 + elapsed_s2;

	// Capture the word, then read the current level's entry.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_s1 <= mode;
			time_s1 <= time_now;
		end
		if (cmd.read) begin
			elapsed_s2 <= time_s1 - stamp_q[idx];
			accum_s2   <= accum_q[idx];
			accum0_s2  <= accum_q[0];
		end
	end

	// Event decode: work out the new state and the result times.
	always_comb begin
		nest_d   = nest_q;
		ovf_d    = ovf_q;
		unf_d    = unf_q;
		mis_d    = mis_q;
		deep_d   = deep_q;
		runs_d   = runs_q;
		halt_d   = halted_q;
		st_we    = 1'b0;
		st_wa    = idx;
		acc_we   = 1'b0;
		acc_wa   = idx;
		acc_wd   = level_sum;
		clr_we   = 1'b0;
		clr_wa   = idx + LVL_ONE;
		popped_d = '0;
		task_d   = '0;
		tadd_d   = '0;
		sadd_d   = '0;
		if (!halted_q) begin
			case (mode_s1)
				MODE_TASK_RESTART: begin
					if (nest_q != '0) begin
						mis_d = mis_q + 32'd1;
					end else begin
						st_we  = 1'b1;
						st_wa  = LVL_ZERO;
						acc_we = 1'b1;
						acc_wa = LVL_ZERO;
						acc_wd = '0;
					end
				end
				MODE_TASK_READ: begin
					if (nest_q != '0) begin
						mis_d = mis_q + 32'd1;
					end else begin
						task_d = level_sum;
					end
				end
				MODE_ENTER: begin
					if (nest_q < MAX_N) begin
						acc_we = 1'b1;
						st_we  = 1'b1;
						st_wa  = idx + LVL_ONE;
						clr_we = 1'b1;
					end else begin
						ovf_d = ovf_q + 32'd1;
					end
					nest_d = nest_q + 32'd1;
				end
				MODE_LEAVE: begin
					if (nest_q > MAX_N) begin
						nest_d = nest_q - 32'd1;
					end else if (nest_q == MAX_N) begin
						// Deepest tracked level: its time goes to the overflow total.
						deep_d = deep_q + {32'd0, level_sum};
						runs_d = runs_q + 32'd1;
						st_we  = 1'b1;
						st_wa  = idx - LVL_ONE;
						nest_d = nest_q - 32'd1;
					end else if (nest_q != '0) begin
						popped_d = level_sum;
						st_we    = 1'b1;
						st_wa    = idx - LVL_ONE;
						nest_d   = nest_q - 32'd1;
					end else begin
						unf_d = unf_q + 32'd1;
					end
				end
				MODE_SCHED_START: begin
					if (nest_q != '0) begin
						halt_d = 1'b1;
					end else begin
						acc_we = 1'b1;
						st_we  = 1'b1;
						st_wa  = LVL_ONE;
						clr_we = 1'b1;
						nest_d = 32'd1;
					end
				end
				MODE_SCHED_END: begin
					if (nest_q != 32'd1) begin
						halt_d = 1'b1;
					end else begin
						nest_d = '0;
						tadd_d = accum0_s2;
						sadd_d = level_sum;
						acc_we = 1'b1;
						acc_wa = LVL_ZERO;
						acc_wd = '0;
						st_we  = 1'b1;
						st_wa  = LVL_ZERO;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// State update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				stamp_q[i] <= '0;
				accum_q[i] <= '0;
			end
			nest_q   <= '0;
			ovf_q    <= '0;
			unf_q    <= '0;
			mis_q    <= '0;
			deep_q   <= '0;
			runs_q   <= '0;
			halted_q <= 1'b0;
		end else if (cmd.exec) begin
			if (st_we) begin
				stamp_q[st_wa] <= time_s1;
			end
			if (acc_we) begin
				accum_q[acc_wa] <= acc_wd;
			end
			if (clr_we) begin
				accum_q[clr_wa] <= '0;
			end
			nest_q   <= nest_d;
			ovf_q    <= ovf_d;
			unf_q    <= unf_d;
			mis_q    <= mis_d;
			deep_q   <= deep_d;
			runs_q   <= runs_d;
			halted_q <= halt_d;
		end
	end

	// Result time registers.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			popped_q <= popped_d;
			task_q   <= task_d;
			tadd_q   <= tadd_d;
			sadd_q   <= sadd_d;
		end
	end

	// State only changes when a result is loaded, so the counters drive the result directly.
	assign popped_time         = popped_q;
	assign task_time           = task_q;
	assign task_time_add       = tadd_q;
	assign sched_time_add      = sadd_q;
	assign overflow_events     = ovf_q;
	assign underflow_events    = unf_q;
	assign misuse_events       = mis_q;
	assign overflow_level_time = deep_q;
	assign overflow_level_runs = runs_q;
	assign nesting_level       = nest_q;
	assign fatal               = halted_q;

endmodule

FILE: src/nested_run_time_accounting_stack_unit.sv
// Nested run-time accounting stack: each input word (mode, time_now) gives one result
// word. A word goes through the controller's three-state sequence: it is captured, then
// the stack entry of the current nesting level is read and the elapsed time formed, then
// the stack and counters are updated and the result register is loaded. The result
// waits in its register, so the next word may be taken while it is still unclaimed; the
// update step waits until the result register is free. After a scheduler start or end
// at the wrong level, fatal rises and every later word is ignored until reset.
module nested_run_time_accounting_stack_unit #(
	parameter int MAX_LEVEL = nrtas_pkg::MAX_LEVEL_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [31:0] time_now,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] popped_time,
	output logic [31:0] task_time,
	output logic [31:0] task_time_add,
	output logic [31:0] sched_time_add,
	output logic [31:0] overflow_events,
	output logic [31:0] underflow_events,
	output logic [31:0] misuse_events,
	output logic [63:0] overflow_level_time,
	output logic [31:0] overflow_level_runs,
	output logic [31:0] nesting_level,
	output logic        fatal
);
	import nrtas_pkg::*;

	ctl_cmd_t cmd;

	// Sequencer and output handshake.
	nrtas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Stack, counters and result registers.
	nrtas_dpath #(
		.MAX_LEVEL (MAX_LEVEL)
	) u_dpath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.mode                (mode),
		.time_now            (time_now),
		.popped_time         (popped_time),
		.task_time           (task_time),
		.task_time_add       (task_time_add),
		.sched_time_add      (sched_time_add),
		.overflow_events     (overflow_events),
		.underflow_events    (underflow_events),
		.misuse_events       (misuse_events),
		.overflow_level_time (overflow_level_time),
		.overflow_level_runs (overflow_level_runs),
		.nesting_level       (nesting_level),
		.fatal               (fatal)
	);

`include "nested_run_time_accounting_stack_unit_defines.svh"

	// A halted block stays halted until reset.
	`NRTAS_ASSERT_NEXT(a_fatal_sticky, fatal, fatal, "fatal dropped without reset")

	// The nesting level moves only in the update step.
	`NRTAS_ASSERT_NEXT(a_nest_only_on_exec, !cmd.exec, $stable(nesting_level), "nesting level moved outside update")

	// A halted block reports no time.
	`NRTAS_ASSERT_NOW(a_halted_no_time, out_valid && fatal, popped_time == 32'd0 && task_time == 32'd0 && task_time_add == 32'd0 && sched_time_add == 32'd0, "time reported while halted")

	// A word taken in is followed by the stack read step.
	`NRTAS_ASSERT_NEXT(a_accept_then_read, in_valid && in_ready, cmd.read && !in_ready, "accepted word not read next")

endmodule

FILE: bench/nested_run_time_accounting_stack_unit_tb.sv
// Self-checking bench for the nested run-time accounting stack, with a queued driver and a monitor.
`timescale 1ns / 100ps

module nested_run_time_accounting_stack_unit_tb;
	import nrtas_pkg::*;

	localparam int DEPTH_MAX = MAX_LEVEL_DEF;

	// The two spare mode codes, which the block ignores.
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	// Number of random words after the directed part, in chunks of equal size.
	localparam int RANDOM_CHUNKS = 6;
	localparam int CHUNK_WORDS = 100;
	localparam int REPORT_CAP = 40;
	localparam int TAIL_CYCLES = 20;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] stamp;
	} timer_event_t;

	typedef struct packed {
		logic [31:0] popped_time;
		logic [31:0] task_time;
		logic [31:0] task_time_add;
		logic [31:0] sched_time_add;
		logic [31:0] overflow_events;
		logic [31:0] underflow_events;
		logic [31:0] misuse_events;
		logic [63:0] overflow_level_time;
		logic [31:0] overflow_level_runs;
		logic [31:0] nesting_level;
		logic        fatal;
	} acct_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  mode = MODE_TASK_RESTART;
	logic [31:0] time_now = 32'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] popped_time;
	logic [31:0] task_time;
	logic [31:0] task_time_add;
	logic [31:0] sched_time_add;
	logic [31:0] overflow_events;
	logic [31:0] underflow_events;
	logic [31:0] misuse_events;
	logic [63:0] overflow_level_time;
	logic [31:0] overflow_level_runs;
	logic [31:0] nesting_level;
	logic        fatal;

	nested_run_time_accounting_stack_unit dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.mode                (mode),
		.time_now            (time_now),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.popped_time         (popped_time),
		.task_time           (task_time),
		.task_time_add       (task_time_add),
		.sched_time_add      (sched_time_add),
		.overflow_events     (overflow_events),
		.underflow_events    (underflow_events),
		.misuse_events       (misuse_events),
		.overflow_level_time (overflow_level_time),
		.overflow_level_runs (overflow_level_runs),
		.nesting_level       (nesting_level),
		.fatal               (fatal)
	);

	always #2 clk = ~clk;

	timer_event_t events_to_send[$];
	acct_word_t   expected_accounts[$];

	int idle_pct = 30;
	int queued_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	int mismatch_count = 0;

	// Predicted state of the accounting stack.
	logic [31:0] lvl_start [0:DEPTH_MAX];
	logic [31:0] lvl_spent [0:DEPTH_MAX];
	logic [31:0] depth_now = 32'd0;
	logic [31:0] over_cnt = 32'd0;
	logic [31:0] under_cnt = 32'd0;
	logic [31:0] misuse_cnt = 32'd0;
	logic [63:0] deep_spent = 64'd0;
	logic [31:0] deep_leaves = 32'd0;
	logic        halted_now = 1'b0;
	logic [31:0] deepest_seen = 32'd0;

	// Stimulus shaping state: nesting as the generator sees it, and the running timer.
	logic [31:0] gen_level = 32'd0;
	logic [31:0] gen_target = 32'd0;
	logic [31:0] gen_clock = 32'hFFF0_0000;

	initial begin
		for (int i = 0; i <= DEPTH_MAX; i++) begin
			lvl_start[i] = 32'd0;
			lvl_spent[i] = 32'd0;
		end
	end

	// Works out the result word for one accepted event and updates the predicted stack.
	task automatic account_word(input logic [2:0] m, input logic [31:0] t);
		acct_word_t w;
		logic [31:0] n;
		logic [31:0] span;
		w = '0;
		n = depth_now;
		if (!halted_now) begin
			case (m)
				MODE_TASK_RESTART: begin
					if (n != 0) begin
						misuse_cnt = misuse_cnt + 1;
					end else begin
						lvl_start[0] = t;
						lvl_spent[0] = 32'd0;
					end
				end
				MODE_TASK_READ: begin
					if (n != 0)
						misuse_cnt = misuse_cnt + 1;
					else
						w.task_time = lvl_spent[0] + (t - lvl_start[0]);
				end
				MODE_ENTER: begin
					if (n < DEPTH_MAX) begin
						lvl_spent[n] = lvl_spent[n] + (t - lvl_start[n]);
						lvl_start[n + 1] = t;
						lvl_spent[n + 1] = 32'd0;
					end else begin
						over_cnt = over_cnt + 1;
					end
					depth_now = n + 1;
				end
				MODE_LEAVE: begin
					if (n > DEPTH_MAX) begin
						depth_now = n - 1;
					end else if (n == DEPTH_MAX) begin
						// The deepest level banks its time in the wide total.
						span = lvl_spent[n] + (t - lvl_start[n]);
						deep_spent = deep_spent + {32'd0, span};
						deep_leaves = deep_leaves + 1;
						lvl_start[n - 1] = t;
						depth_now = n - 1;
					end else if (n != 0) begin
						w.popped_time = lvl_spent[n] + (t - lvl_start[n]);
						lvl_start[n - 1] = t;
						depth_now = n - 1;
					end else begin
						under_cnt = under_cnt + 1;
					end
				end
				MODE_SCHED_START: begin
					if (n != 0) begin
						halted_now = 1'b1;
					end else begin
						lvl_spent[0] = lvl_spent[0] + (t - lvl_start[0]);
						lvl_start[1] = t;
						lvl_spent[1] = 32'd0;
						depth_now = 32'd1;
					end
				end
				MODE_SCHED_END: begin
					if (n != 1) begin
						halted_now = 1'b1;
					end else begin
						depth_now = 32'd0;
						w.task_time_add = lvl_spent[0];
						lvl_spent[0] = 32'd0;
						w.sched_time_add = lvl_spent[1] + (t - lvl_start[1]);
						lvl_start[0] = t;
					end
				end
				default: begin
				end
			endcase
		end
		if (depth_now > deepest_seen)
			deepest_seen = depth_now;
		w.overflow_events = over_cnt;
		w.underflow_events = under_cnt;
		w.misuse_events = misuse_cnt;
		w.overflow_level_time = deep_spent;
		w.overflow_level_runs = deep_leaves;
		w.nesting_level = depth_now;
		w.fatal = halted_now;
		expected_accounts.push_back(w);
	endtask

	// Length of an idle stretch: mostly none or short, now and then long.
	function automatic int idle_span();
		if ($urandom_range(0, 99) >= idle_pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	// Next timer value: usually a small step, sometimes a big jump or an arbitrary value.
	function automatic logic [31:0] fresh_stamp();
		int unsigned r = $urandom_range(0, 99);
		if (r < 80)
			gen_clock = gen_clock + $urandom_range(1, 4000);
		else if (r < 95)
			gen_clock = gen_clock + $urandom;
		else
			gen_clock = $urandom;
		return gen_clock;
	endfunction

	// Queues one event and follows the nesting level that it leads to.
	task automatic queue_word(input logic [2:0] m, input logic [31:0] t);
		timer_event_t ev;
		ev.mode = m;
		ev.stamp = t;
		events_to_send.push_back(ev);
		queued_count++;
		case (m)
			MODE_ENTER: gen_level = gen_level + 1;
			MODE_LEAVE: if (gen_level != 0) gen_level = gen_level - 1;
			MODE_SCHED_START: if (gen_level == 0) gen_level = 32'd1;
			MODE_SCHED_END: if (gen_level == 1) gen_level = 32'd0;
			default: begin
			end
		endcase
	endtask

	// One random step: a walk towards a moving target depth, with some noise mixed in.
	task automatic queue_random_step();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			case ($urandom_range(0, 3))
				0: queue_word(MODE_TASK_RESTART, fresh_stamp());
				1: queue_word(MODE_TASK_READ, fresh_stamp());
				2: queue_word($urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI, $urandom);
				default: queue_word(MODE_LEAVE, fresh_stamp());
			endcase
		end else if (gen_level == gen_target) begin
			if (gen_level == 0)
				queue_word($urandom_range(0, 1) ? MODE_TASK_READ : MODE_TASK_RESTART,
					fresh_stamp());
			r = $urandom_range(0, 99);
			if (r < 30)
				gen_target = 32'd0;
			else if (r < 50)
				gen_target = 32'd1;
			else if (r < 85)
				gen_target = $urandom_range(2, DEPTH_MAX - 1);
			else
				gen_target = $urandom_range(DEPTH_MAX, DEPTH_MAX + 3);
		end else if (gen_level < gen_target) begin
			if (gen_level == 0 && $urandom_range(0, 1) == 1)
				queue_word(MODE_SCHED_START, fresh_stamp());
			else
				queue_word(MODE_ENTER, fresh_stamp());
		end else begin
			if (gen_level == 1 && $urandom_range(0, 2) != 0)
				queue_word(MODE_SCHED_END, fresh_stamp());
			else
				queue_word(MODE_LEAVE, fresh_stamp());
		end
	endtask

	// Compares one field of a result word and reports a difference.
	task automatic compare_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_CAP)
				$display("%0t: %s expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Driver: presents queued words, with random gaps between them.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		timer_event_t ev;
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= MODE_TASK_RESTART;
			time_now <= 32'd0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				account_word(mode, time_now);
				sent_count++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (events_to_send.size() != 0) begin
					ev = events_to_send.pop_front();
					in_valid <= 1'b1;
					mode <= ev.mode;
					time_now <= ev.stamp;
					send_gap <= idle_span();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: takes result words with random stalls and checks them in order.
	int hold_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		acct_word_t w;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_accounts.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_CAP)
						$display("%0t: result word expected none, actual nesting_level %h",
							$time, nesting_level);
				end else begin
					w = expected_accounts.pop_front();
					checked_count++;
					compare_field("popped_time", 64'(w.popped_time), 64'(popped_time));
					compare_field("task_time", 64'(w.task_time), 64'(task_time));
					compare_field("task_time_add", 64'(w.task_time_add),
						64'(task_time_add));
					compare_field("sched_time_add", 64'(w.sched_time_add),
						64'(sched_time_add));
					compare_field("overflow_events", 64'(w.overflow_events),
						64'(overflow_events));
					compare_field("underflow_events", 64'(w.underflow_events),
						64'(underflow_events));
					compare_field("misuse_events", 64'(w.misuse_events),
						64'(misuse_events));
					compare_field("overflow_level_time", w.overflow_level_time,
						overflow_level_time);
					compare_field("overflow_level_runs", 64'(w.overflow_level_runs),
						64'(overflow_level_runs));
					compare_field("nesting_level", 64'(w.nesting_level),
						64'(nesting_level));
					compare_field("fatal", 64'(w.fatal), 64'(fatal));
				end
			end
			if (hold_gap > 0) begin
				hold_gap <= hold_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				hold_gap <= idle_span();
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int chunk_start;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: timer wrap, underflow, misuse, overflow and the deepest level.
		idle_pct = 30;
		queue_word(MODE_TASK_RESTART, 32'hFFFF_FFF0);
		queue_word(MODE_TASK_READ, 32'h0000_0010);
		queue_word(MODE_LEAVE, 32'hFFFF_FFFF);
		queue_word(MODE_SCHED_START, 32'h0000_0000);
		queue_word(MODE_TASK_RESTART, 32'hFFFF_FFFF);
		queue_word(MODE_TASK_READ, 32'h0000_0000);
		for (int i = 1; i < DEPTH_MAX; i++)
			queue_word(MODE_ENTER, fresh_stamp());
		queue_word(MODE_ENTER, 32'hFFFF_FFFF);
		queue_word(MODE_ENTER, 32'h0000_0000);
		queue_word(MODE_LEAVE, fresh_stamp());
		queue_word(MODE_LEAVE, fresh_stamp());
		queue_word(MODE_LEAVE, $urandom);
		for (int i = 1; i < DEPTH_MAX - 1; i++)
			queue_word(MODE_LEAVE, fresh_stamp());
		queue_word(MODE_SCHED_END, 32'hFFFF_FFFF);
		queue_word(MODE_SPARE_LO, 32'hFFFF_FFFF);
		queue_word(MODE_SPARE_HI, 32'h0000_0000);

		// Random part, with a fresh idling rate for each chunk.
		for (int c = 0; c < RANDOM_CHUNKS; c++) begin
			while (events_to_send.size() != 0)
				@(posedge clk);
			case ($urandom_range(0, 3))
				0: idle_pct = 0;
				1: idle_pct = 15;
				2: idle_pct = 40;
				default: idle_pct = 70;
			endcase
			// Some steps only pick a new target, so keep stepping until the chunk is full.
			chunk_start = queued_count;
			while (queued_count < chunk_start + CHUNK_WORDS)
				queue_random_step();
		end

		// Misplaced scheduler start or end halts the block; every later word is ignored.
		if ($urandom_range(0, 1) == 1) begin
			if (gen_level == 0)
				queue_word(MODE_ENTER, fresh_stamp());
			queue_word(MODE_SCHED_START, fresh_stamp());
		end else begin
			if (gen_level == 1)
				queue_word(MODE_ENTER, fresh_stamp());
			queue_word(MODE_SCHED_END, fresh_stamp());
		end
		queue_word(MODE_TASK_RESTART, $urandom);
		queue_word(MODE_TASK_READ, $urandom);
		queue_word(MODE_ENTER, $urandom);
		queue_word(MODE_LEAVE, $urandom);
		queue_word(MODE_SCHED_START, $urandom);
		queue_word(MODE_SCHED_END, $urandom);
		queue_word(MODE_SPARE_LO, $urandom);
		queue_word(MODE_SPARE_HI, $urandom);

		while (sent_count != queued_count)
			@(posedge clk);
		while (expected_accounts.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_accounts.size() != 0) begin
			mismatch_count++;
			$display("%0t: %0d result words expected, actual none", $time,
				expected_accounts.size());
		end

		$display("Run covered %0d events and %0d checked results; deepest nesting %0d.",
			sent_count, checked_count, deepest_seen);
		$display("Deep-level leaves %0d, overflows %0d, underflows %0d, misuses %0d, halted %0d.",
			deep_leaves, over_cnt, under_cnt, misuse_cnt, halted_now);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
